// ===== src/oaht_pkg.sv =====
// Shared constants, codes and types for the open-address hash table.
package oaht_pkg;

    // Table geometry; the table size must be a power of two
    localparam int TABLE_SIZE = 8;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    localparam int STEP_W     = $clog2(TABLE_SIZE + 2);

    // Field widths
    localparam int ACTION_W   = 2;
    localparam int KEY_W      = 31;
    localparam int STATUS_W   = 2;
    localparam int OUT_SLOT_W = 3;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    // Slot marks
    typedef enum logic [1:0] {
        MARK_FREE     = 2'd0,
        MARK_OCCUPIED = 2'd1,
        MARK_REMOVED  = 2'd2
    } t_mark;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic advance;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic probe_end;
    } t_dp_status;

endpackage

// ===== src/oaht_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/oaht_ctrl.sv =====
// Control state machine: input/output handshakes and probe sequencing.
module oaht_ctrl import oaht_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic {
        S_IDLE,
        S_PROBE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   load, advance, finish;

    // Decode commands from state and handshakes
    assign o_in_ready = (r_state == S_IDLE);
    assign load       = i_in_valid && (r_state == S_IDLE);
    assign advance    = (r_state == S_PROBE) && !i_status.probe_end;
    assign finish     = (r_state == S_PROBE) && i_status.probe_end &&
                        (!r_out_valid || i_out_ready);

    assign o_cmd.load    = load;
    assign o_cmd.advance = advance;
    assign o_cmd.finish  = finish;

    // Next state and output valid
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (load) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/oaht_dp.sv =====
// Datapath: probe position, slot marks, key store compare and result register.
module oaht_dp import oaht_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [KEY_W-1:0]      i_key,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output logic [STATUS_W-1:0]   o_status_code,
    output logic [OUT_SLOT_W-1:0] o_slot
);

    logic [ACTION_W-1:0]   r_action;
    logic [KEY_W-1:0]      r_key;
    logic [SLOT_W-1:0]     r_pos, n_pos;
    logic [STEP_W-1:0]     r_step;
    t_mark                 r_marks [TABLE_SIZE];
    logic [STATUS_W-1:0]   r_res_status;
    logic [OUT_SLOT_W-1:0] r_res_slot;

    logic [KEY_W-1:0]      stored_key;
    t_mark                 cur_mark;
    logic                  key_hit;
    logic                  probe_end;
    logic                  res_ok;
    logic [STATUS_W-1:0]   res_status;
    logic                  wr_key;
    logic                  wr_mark;
    t_mark                 wr_mark_val;

    // Next probe position; hold the current one while waiting
    always_comb begin
        n_pos = r_pos;
        if (i_cmd.load) begin
            n_pos = i_key[SLOT_W-1:0];
        end else if (i_cmd.advance) begin
            n_pos = r_pos + SLOT_W'(r_step);
        end
    end

    // Key store; read address is n_pos, so the registered read data lines up with r_pos
    oaht_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SIZE)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (wr_key),
        .i_waddr (r_pos),
        .i_wdata (r_key),
        .i_raddr (n_pos),
        .o_rdata (stored_key)
    );

    assign cur_mark = r_marks[r_pos];
    assign key_hit  = (stored_key == r_key);

    // Evaluate the current probe
    always_comb begin
        probe_end   = 1'b1;
        res_ok      = 1'b0;
        res_status  = ST_ABSENT;
        wr_key      = 1'b0;
        wr_mark     = 1'b0;
        wr_mark_val = MARK_OCCUPIED;
        case (r_action)
            ACT_INSERT: begin
                probe_end = (cur_mark != MARK_OCCUPIED) ||
                            (r_step == STEP_W'(TABLE_SIZE));
                res_ok     = (cur_mark != MARK_OCCUPIED);
                res_status = res_ok ? ST_OK : ST_FULL;
                wr_key     = res_ok && i_cmd.finish;
                wr_mark    = wr_key;
            end
            ACT_SEARCH, ACT_REMOVE: begin
                // stop at a free slot, a key match, or after the last step
                probe_end = (cur_mark == MARK_FREE) || key_hit ||
                            (r_step == STEP_W'(TABLE_SIZE + 1));
                res_ok     = (cur_mark == MARK_OCCUPIED) && key_hit;
                res_status = res_ok ? ST_OK : ST_ABSENT;
                wr_mark     = res_ok && i_cmd.finish && (r_action == ACT_REMOVE);
                wr_mark_val = MARK_REMOVED;
            end
            default: begin
                probe_end  = 1'b1;
                res_status = ST_ABSENT;
            end
        endcase
    end

    assign o_status.probe_end = probe_end;

    // Capture the item and advance the probe
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_key    <= i_key;
            r_step   <= STEP_W'(1);
        end else if (i_cmd.advance) begin
            r_step <= r_step + STEP_W'(1);
        end
        r_pos <= n_pos;
    end

    // Slot marks; reset frees every slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
                r_marks[i] <= MARK_FREE;
            end
        end else if (wr_mark) begin
            r_marks[r_pos] <= wr_mark_val;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res_status <= res_status;
            r_res_slot   <= res_ok ? OUT_SLOT_W'(r_pos) : '0;
        end
    end

    assign o_status_code = r_res_status;
    assign o_slot        = r_res_slot;

endmodule

// ===== src/open_address_hash_table_core.sv =====
// Top level of the open-address hash table with triangular probing.
//
//   channel | signals                      | payload
//   --------+------------------------------+------------------
//   input   | i_in_valid / o_in_ready      | i_action, i_key
//   output  | o_out_valid / i_out_ready    | o_status, o_slot
//
// An item is loaded and then probed one slot per cycle, up to TABLE_SIZE probes for
// insert and TABLE_SIZE + 1 for search and remove, except that the last probe can
// hold as described below. A new item is taken the cycle after the previous result is
// registered. A finished result waits in the output register; a following item is
// accepted and probed meanwhile and holds on its last probe until the output
// register frees. Reset marks every slot free at once.
module open_address_hash_table_core import oaht_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [KEY_W-1:0]      i_key,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [STATUS_W-1:0]   o_status,
    output logic [OUT_SLOT_W-1:0] o_slot
);

    t_dp_cmd    cmd;
    t_dp_status dp_status;

    oaht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (dp_status)
    );

    oaht_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_action      (i_action),
        .i_key         (i_key),
        .i_cmd         (cmd),
        .o_status      (dp_status),
        .o_status_code (o_status),
        .o_slot        (o_slot)
    );

endmodule

// ===== bench/open_address_hash_table_core_test.sv =====
// Self-checking testbench for the open-address hash table core.
module open_address_hash_table_core_test import oaht_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Action code outside the defined set; the core must ignore it
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int N_DIRECTED    = 25;
    localparam int N_RANDOM      = 600;
    localparam int KEY_POOL_SIZE = 12;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_CYCLES  = 24;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [OUT_SLOT_W-1:0] slot;
    } t_result;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    key;
        bit                  fixed;
        t_result             want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [ACTION_W-1:0]   i_action;
    logic [KEY_W-1:0]      i_key;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [STATUS_W-1:0]   o_status;
    logic [OUT_SLOT_W-1:0] o_slot;

    // Shadow copy of the table contents
    logic [KEY_W-1:0] shadow_keys  [TABLE_SIZE];
    t_mark            shadow_marks [TABLE_SIZE];

    t_result          expected_results [$];
    logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];
    int               mismatch_count = 0;
    bit               send_burst     = 1'b0;
    bit               drain_burst    = 1'b0;

    // Directed rows; fixed answers only where they are obvious
    t_row directed_rows [N_DIRECTED] = '{
        '{ACT_SEARCH, 31'd0,          1'b1, '{ST_ABSENT, 3'd0}},
        '{ACT_REMOVE, 31'd5,          1'b1, '{ST_ABSENT, 3'd0}},
        '{ACT_UNUSED, 31'h7FFF_FFFF,  1'b1, '{ST_ABSENT, 3'd0}},
        '{ACT_INSERT, 31'd0,          1'b1, '{ST_OK,     3'd0}},
        '{ACT_INSERT, 31'h7FFF_FFFF,  1'b1, '{ST_OK,     3'd7}},
        '{ACT_SEARCH, 31'h7FFF_FFFF,  1'b1, '{ST_OK,     3'd7}},
        '{ACT_INSERT, 31'd8,          1'b0, '{ST_OK,     3'd0}},
        '{ACT_INSERT, 31'd16,         1'b0, '{ST_OK,     3'd0}},
        '{ACT_INSERT, 31'd0,          1'b0, '{ST_OK,     3'd0}},
        '{ACT_SEARCH, 31'd16,         1'b0, '{ST_OK,     3'd0}},
        '{ACT_REMOVE, 31'd8,          1'b0, '{ST_OK,     3'd0}},
        '{ACT_SEARCH, 31'd8,          1'b0, '{ST_OK,     3'd0}},
        '{ACT_REMOVE, 31'd8,          1'b0, '{ST_OK,     3'd0}},
        '{ACT_INSERT, 31'd24,         1'b0, '{ST_OK,     3'd0}},
        '{ACT_SEARCH, 31'd16,         1'b0, '{ST_OK,     3'd0}},
        '{ACT_INSERT, 31'h2AAA_AAAA,  1'b0, '{ST_OK,     3'd0}},
        '{ACT_INSERT, 31'h5555_5555,  1'b0, '{ST_OK,     3'd0}},
        '{ACT_INSERT, 31'h1234_5674,  1'b0, '{ST_OK,     3'd0}},
        '{ACT_INSERT, 31'h7FFF_FFFF,  1'b1, '{ST_FULL,   3'd0}},
        '{ACT_SEARCH, 31'd3,          1'b1, '{ST_ABSENT, 3'd0}},
        '{ACT_REMOVE, 31'h5555_5555,  1'b0, '{ST_OK,     3'd0}},
        '{ACT_REMOVE, 31'd0,          1'b0, '{ST_OK,     3'd0}},
        '{ACT_SEARCH, 31'd0,          1'b0, '{ST_OK,     3'd0}},
        '{ACT_UNUSED, 31'd0,          1'b1, '{ST_ABSENT, 3'd0}},
        '{ACT_INSERT, 31'd3,          1'b0, '{ST_OK,     3'd0}}
    };

    open_address_hash_table_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_key       (i_key),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_slot      (o_slot)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Walk the probe sequence; return 1 with the slot when a live copy of key is found
    function automatic bit find_live_key(input logic [KEY_W-1:0] key, output int where);
        int pos;
        int step;
        pos  = int'(key % TABLE_SIZE);
        step = 1;
        while (step <= TABLE_SIZE && shadow_marks[pos] != MARK_FREE &&
               shadow_keys[pos] != key) begin
            pos = (pos + step) % TABLE_SIZE;
            step++;
        end
        where = pos;
        return shadow_marks[pos] == MARK_OCCUPIED && shadow_keys[pos] == key;
    endfunction

    // Apply one operation to the shadow table and return its answer
    function automatic t_result hash_table_update(input logic [ACTION_W-1:0] action,
                                                  input logic [KEY_W-1:0] key);
        t_result answer;
        int      pos;
        int      step;
        answer = '{ST_ABSENT, '0};
        case (action)
            ACT_INSERT: begin
                pos  = int'(key % TABLE_SIZE);
                step = 1;
                while (step <= TABLE_SIZE && shadow_marks[pos] == MARK_OCCUPIED) begin
                    pos = (pos + step) % TABLE_SIZE;
                    step++;
                end
                if (step <= TABLE_SIZE) begin
                    shadow_keys[pos]  = key;
                    shadow_marks[pos] = MARK_OCCUPIED;
                    answer = '{ST_OK, OUT_SLOT_W'(pos)};
                end else begin
                    answer = '{ST_FULL, '0};
                end
            end
            ACT_SEARCH: begin
                if (find_live_key(key, pos)) begin
                    answer = '{ST_OK, OUT_SLOT_W'(pos)};
                end
            end
            ACT_REMOVE: begin
                if (find_live_key(key, pos)) begin
                    shadow_marks[pos] = MARK_REMOVED;
                    answer = '{ST_OK, OUT_SLOT_W'(pos)};
                end
            end
            default: begin
                answer = '{ST_ABSENT, '0};
            end
        endcase
        return answer;
    endfunction

    task automatic note_mismatch(input string what, input t_result want, input t_result got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] %s: expected status %0d slot %0d, got status %0d slot %0d",
                     $realtime, what, want.status, want.slot, got.status, got.slot);
        end
    endtask

    // Present one item after a random gap and hold it until the transfer
    task automatic send_item(input logic [ACTION_W-1:0] action, input logic [KEY_W-1:0] key,
                             input bit fixed, input t_result fixed_want);
        int      gap;
        t_result predicted;
        if ($urandom_range(0, 31) == 0) begin
            send_burst = !send_burst;
        end
        gap = send_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= action;
        i_key      <= key;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        predicted = hash_table_update(action, key);
        expected_results.push_back(fixed ? fixed_want : predicted);
    endtask

    // Draw a random key; collide on the low bits often
    function automatic logic [KEY_W-1:0] fresh_key();
        logic [31:0] raw;
        raw      = $urandom();
        raw[2:0] = 3'($urandom_range(0, 3));
        return raw[KEY_W-1:0];
    endfunction

    // Stimulus
    initial begin
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    key;
        int                  pick;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_action   <= ACT_INSERT;
        i_key      <= '0;
        for (int s = 0; s < TABLE_SIZE; s++) begin
            shadow_keys[s]  = '0;
            shadow_marks[s] = MARK_FREE;
        end
        for (int p = 0; p < KEY_POOL_SIZE; p++) begin
            key_pool[p] = fresh_key();
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            send_item(directed_rows[r].action, directed_rows[r].key,
                      directed_rows[r].fixed, directed_rows[r].want);
        end

        // Random mix over a small key pool so searches and removes hit
        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                action = ACT_INSERT;
            end else if (pick < 65) begin
                action = ACT_SEARCH;
            end else if (pick < 95) begin
                action = ACT_REMOVE;
            end else begin
                action = ACT_UNUSED;
            end
            if ($urandom_range(0, 19) == 0) begin
                key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)] = fresh_key();
            end
            if ($urandom_range(0, 9) == 0) begin
                key = KEY_W'($urandom());
            end else begin
                key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
            end
            send_item(action, key, 1'b0, '{ST_OK, '0});
        end
        i_in_valid <= 1'b0;

        // Drain outstanding results, then let the core settle
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Result side: random stalls with occasional bursts of back-to-back acceptance
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                drain_burst = !drain_burst;
            end
            stall = drain_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!o_out_valid);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_status, o_slot};
            if (expected_results.size() == 0) begin
                note_mismatch("unexpected result", '{'x, 'x}, got);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.slot !== want.slot) begin
                    note_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // Hard stop for a hung handshake
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
